// ===== design/avrs_pkg.sv =====
// Shared types, constants and helpers of the ADC reference ratiometric scaler.
// No dependencies; every other design file imports this package.
package avrs_pkg;

    localparam int unsigned RAW_W = 16;
    localparam int unsigned SUPPLY_W = 31;
    localparam int unsigned RES_W = 32;
    localparam int unsigned VREFINT_W = 21;
    localparam int unsigned FDIV_W = 11;
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 16;
    localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
    localparam int unsigned DIVR_W = 16;
    localparam int unsigned CNT_W = $clog2(PROD_W);
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned NUM_CH = 5;
    localparam int unsigned CH_W = 3;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET_DEFAULT = 31'd3300000;

    localparam logic [CFG_IDX_W-1:0] REG_VREFINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_DIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_NUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_DEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_NUM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_DEN = 3'd6;

    localparam logic [CH_W-1:0] CH_LEFT_V = 3'd0;
    localparam logic [CH_W-1:0] CH_RIGHT_V = 3'd1;
    localparam logic [CH_W-1:0] CH_LEFT_I = 3'd2;
    localparam logic [CH_W-1:0] CH_RIGHT_I = 3'd3;
    localparam logic [CH_W-1:0] CH_MAIN_I = 3'd4;

    typedef enum logic [1:0] {
        J_SUPPLY = 2'd0,
        J_FILTER = 2'd1,
        J_PIN    = 2'd2,
        J_SCALE  = 2'd3
    } job_t;

    typedef struct packed {
        logic [RAW_W-1:0] ref_code;
        logic [RAW_W-1:0] left_voltage_raw;
        logic [RAW_W-1:0] right_voltage_raw;
        logic [RAW_W-1:0] left_current_raw;
        logic [RAW_W-1:0] right_current_raw;
        logic [RAW_W-1:0] main_current_raw;
    } scan_t;

    typedef struct packed {
        logic [SUPPLY_W-1:0]     supply_uv;
        logic signed [RES_W-1:0] left_voltage;
        logic signed [RES_W-1:0] right_voltage;
        logic signed [RES_W-1:0] left_current;
        logic signed [RES_W-1:0] right_current;
        logic signed [RES_W-1:0] main_current;
    } result_t;

    typedef struct packed {
        logic            in_ready;
        logic            mul_en;
        logic            div_start;
        logic            wb_en;
        logic            load_out;
        job_t            job;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic vref_nz;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [MUL_B_W-1:0] nz16(input logic [MUL_B_W-1:0] v);
        nz16 = (v == '0) ? {{(MUL_B_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

// ===== design/avrs_intf.sv =====
// Valid/ready channel interfaces for scans, results and register writes.
// Depends on avrs_pkg for the payload types.
interface avrs_scan_if;
    import avrs_pkg::*;
    logic  valid;
    logic  ready;
    scan_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface avrs_result_if;
    import avrs_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface avrs_cfg_if;
    import avrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/adc_vref_ratiometric_scaler.sv =====
// Each job passes through the shared 48-step divider; a scan runs 12 jobs with a nonzero
// reference code and 10 jobs without. One scan is handled at a time; the next scan is
// taken while a result awaits transfer; the sequence stalls until that result is taken.
// Reset: asynchronous, active low; config registers return to defaults, supply estimate to
// SUPPLY_RESET_UV. Depends on avrs_pkg, avrs_intf, avrs_ctrl and avrs_datapath.
module adc_vref_ratiometric_scaler #(
    parameter logic [avrs_pkg::SUPPLY_W-1:0] SUPPLY_RESET_UV = avrs_pkg::SUPPLY_RESET_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    avrs_scan_if.sink       scan,
    avrs_result_if.source   result,
    avrs_cfg_if.sink        cfg
);
    import avrs_pkg::*;

    cmd_t    cmd;
    status_t status;

    avrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    avrs_datapath #(
        .SUPPLY_RESET_UV (SUPPLY_RESET_UV)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// ===== design/avrs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on avrs_pkg for widths.
module avrs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [avrs_pkg::PROD_W-1:0]   dividend,
    input  logic [avrs_pkg::DIVR_W-1:0]   divisor,
    output logic                          done,
    output logic [avrs_pkg::PROD_W-1:0]   quotient
);
    import avrs_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIVR_W-1:0]   rem_reg, rem_next;
    logic [DIVR_W-1:0]   dvs_reg, dvs_next;
    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [DIVR_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        trial = {rem_reg, quo_reg[PROD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvs_next = divisor;
            quo_next = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVR_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider started while busy");

endmodule

// ===== design/avrs_datapath.sv =====
// Datapath: configuration registers, scan and result registers, shared multiplier,
// shared divider and saturation. Depends on avrs_pkg, avrs_intf and avrs_div.
module avrs_datapath #(
    parameter logic [avrs_pkg::SUPPLY_W-1:0] SUPPLY_RESET_UV = avrs_pkg::SUPPLY_RESET_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    avrs_scan_if.sink            scan,
    avrs_result_if.source        result,
    avrs_cfg_if.sink             cfg,
    input  avrs_pkg::cmd_t       cmd,
    output avrs_pkg::status_t    status
);
    import avrs_pkg::*;

    localparam logic [PROD_W-1:0] POS_MAX = PROD_W'(32'h7FFF_FFFF);
    localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(32'h8000_0000);
    localparam logic signed [RES_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RES_W-1:0] I32_MIN = 32'sh8000_0000;

    logic [VREFINT_W-1:0] vrefint_reg;
    logic [RAW_W-1:0]     fscale_reg;
    logic [FDIV_W-1:0]    fdiv_reg;
    logic [RAW_W-1:0]     vnum_reg, vden_reg, inum_reg, iden_reg;

    scan_t                in_reg;
    result_t              out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SUPPLY_W-1:0]  supply_reg, inst_reg, pin_reg;
    logic signed [RES_W-1:0] res_reg [NUM_CH];
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_neg;
    logic [DIVR_W-1:0]    dvs;
    logic [RAW_W-1:0]     raw;
    logic signed [SUPPLY_W+1:0] diff;
    logic [PROD_W-1:0]    quo;
    logic                 div_done;
    logic [SUPPLY_W-1:0]  pos_sat;
    logic signed [RES_W-1:0] sgn_sat, ch_res;
    logic signed [SUPPLY_W+2:0] filt;
    logic [SUPPLY_W-1:0]  filt_sat;

    assign scan.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        case (cmd.ch)
            CH_LEFT_V:  raw = in_reg.left_voltage_raw;
            CH_RIGHT_V: raw = in_reg.right_voltage_raw;
            CH_LEFT_I:  raw = in_reg.left_current_raw;
            CH_RIGHT_I: raw = in_reg.right_current_raw;
            default:    raw = in_reg.main_current_raw;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_neg = 1'b0;
        dvs = {{(DIVR_W-1){1'b0}}, 1'b1};
        diff = '0;
        case (cmd.job)
            J_SUPPLY:
            begin
                mul_a = MUL_A_W'(vrefint_reg);
                mul_b = nz16(fscale_reg);
                dvs = in_reg.ref_code;
            end
            J_FILTER:
            begin
                diff = $signed({2'b00, inst_reg}) - $signed({2'b00, supply_reg});
                mul_neg = diff[SUPPLY_W+1];
                mul_a = mul_neg ? MUL_A_W'(-diff) : MUL_A_W'(diff);
                mul_b = {{(MUL_B_W-1){1'b0}}, 1'b1};
                dvs = (fdiv_reg == '0) ? {{(DIVR_W-1){1'b0}}, 1'b1} : DIVR_W'(fdiv_reg);
            end
            J_PIN:
            begin
                mul_a = MUL_A_W'(supply_reg);
                mul_b = raw;
                dvs = nz16(fscale_reg);
            end
            default:
            begin
                if (cmd.ch == CH_LEFT_V || cmd.ch == CH_RIGHT_V)
                begin
                    mul_a = MUL_A_W'(pin_reg);
                    mul_b = vnum_reg;
                    dvs = nz16(vden_reg);
                end
                else
                begin
                    diff = $signed({2'b00, pin_reg}) - $signed({3'b000, supply_reg[SUPPLY_W-1:1]});
                    mul_neg = diff[SUPPLY_W+1];
                    mul_a = mul_neg ? MUL_A_W'(-diff) : MUL_A_W'(diff);
                    mul_b = inum_reg;
                    dvs = nz16(iden_reg);
                end
            end
        endcase
    end

    avrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        pos_sat = (quo > POS_MAX) ? SUPPLY_W'(POS_MAX) : quo[SUPPLY_W-1:0];
        if (!neg_reg)
        begin
            sgn_sat = (quo > POS_MAX) ? I32_MAX : $signed(quo[RES_W-1:0]);
        end
        else
        begin
            sgn_sat = (quo > NEG_MAX) ? I32_MIN : -$signed(quo[RES_W-1:0]);
        end
        if (cmd.ch == CH_LEFT_I || cmd.ch == CH_RIGHT_I)
        begin
            ch_res = (sgn_sat == I32_MIN) ? I32_MAX : -sgn_sat;
        end
        else
        begin
            ch_res = sgn_sat;
        end
        filt = $signed({3'b000, supply_reg}) + $signed({{2{sgn_sat[RES_W-1]}}, sgn_sat});
        if (filt < 0)
        begin
            filt_sat = '0;
        end
        else if (filt > $signed({3'b000, SUPPLY_W'(POS_MAX)}))
        begin
            filt_sat = SUPPLY_W'(POS_MAX);
        end
        else
        begin
            filt_sat = filt[SUPPLY_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vrefint_reg <= 21'd1212000;
            fscale_reg <= 16'd4095;
            fdiv_reg <= 11'd16;
            vnum_reg <= 16'd1;
            vden_reg <= 16'd1;
            inum_reg <= 16'd1;
            iden_reg <= 16'd1;
            supply_reg <= SUPPLY_RESET_UV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_VREFINT:    vrefint_reg <= cfg.data;
                    REG_FULL_SCALE: fscale_reg <= cfg.data[RAW_W-1:0];
                    REG_FILTER_DIV: fdiv_reg <= cfg.data[FDIV_W-1:0];
                    REG_VOLT_NUM:   vnum_reg <= cfg.data[RAW_W-1:0];
                    REG_VOLT_DEN:   vden_reg <= cfg.data[RAW_W-1:0];
                    REG_CURR_NUM:   inum_reg <= cfg.data[RAW_W-1:0];
                    REG_CURR_DEN:   iden_reg <= cfg.data[RAW_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.wb_en && cmd.job == J_FILTER)
            begin
                supply_reg <= filt_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ready && scan.valid)
        begin
            in_reg <= scan.data;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            neg_reg <= mul_neg;
        end
        if (cmd.wb_en)
        begin
            case (cmd.job)
                J_SUPPLY: inst_reg <= pos_sat;
                J_PIN:    pin_reg <= pos_sat;
                J_SCALE:  res_reg[cmd.ch] <= ch_res;
                default:  ;
            endcase
        end
        if (cmd.load_out)
        begin
            out_reg.supply_uv <= supply_reg;
            out_reg.left_voltage <= res_reg[CH_LEFT_V];
            out_reg.right_voltage <= res_reg[CH_RIGHT_V];
            out_reg.left_current <= res_reg[CH_LEFT_I];
            out_reg.right_current <= res_reg[CH_RIGHT_I];
            out_reg.main_current <= res_reg[CH_MAIN_I];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_reg;

    assign status.in_valid = scan.valid;
    assign status.vref_nz = (in_reg.ref_code != '0);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || result.ready;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten before transfer");

endmodule

// ===== design/avrs_ctrl.sv =====
// Controller: sequences the supply, filter, pin and scaling jobs of one scan.
// Depends on avrs_pkg for the command and status types.
module avrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  avrs_pkg::status_t  status,
    output avrs_pkg::cmd_t     cmd
);
    import avrs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEL   = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_START = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_WB    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    job_t            job_reg, job_next;
    logic [CH_W-1:0] ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        ch_next = ch_reg;
        cmd = '0;
        cmd.job = job_reg;
        cmd.ch = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                job_next = status.vref_nz ? J_SUPPLY : J_PIN;
                ch_next = CH_LEFT_V;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.wb_en = 1'b1;
                state_next = S_MUL;
                case (job_reg)
                    J_SUPPLY: job_next = J_FILTER;
                    J_FILTER: job_next = J_PIN;
                    J_PIN:    job_next = J_SCALE;
                    default:
                    begin
                        job_next = J_PIN;
                        ch_next = CH_W'(ch_reg + 1'b1);
                        if (ch_reg == CH_MAIN_I)
                        begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= J_PIN;
            ch_reg <= CH_LEFT_V;
        end
        else
        begin
            state_reg <= state_next;
            job_reg <= job_next;
            ch_reg <= ch_next;
        end
    end

    a_accept_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.in_ready && status.in_valid) |=> state_reg == S_SEL)
        else $error("accepted scan did not start a sequence");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_WAIT)
        else $error("divider finished outside the wait state");
    a_filter_vref: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && job_reg == J_FILTER) |-> status.vref_nz)
        else $error("supply filter run with a zero reference code");

endmodule
